FILE: sv/pkps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkps_pkg
// Shared constants and types of the keyword preflight scanner.
// ----------------------------------------------------------------------------
package pkps_pkg;

   localparam int unsigned MAX_BYTES = 268435456;
   localparam int unsigned CNT_W     = 29;
   localparam int unsigned TALLY_W   = 27;
   localparam int unsigned MIN_LEN   = 8;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   // per-byte classification handed from the front to the back
   typedef struct packed {
      logic hdr_bad;
      logic obj;
      logic javascript;
      logic launch;
      logic embedded;
      logic auto_open;
      logic xref;
      logic eof;
      logic last;
   } class_type;

   typedef struct packed {
      logic               status;
      logic               malformed;
      logic               has_javascript;
      logic               has_launch;
      logic               has_embedded_file;
      logic               has_open_action;
      logic               xref_absent;
      logic               eof_absent;
      logic [TALLY_W-1:0] object_total;
   } summary_type;

endpackage
`default_nettype wire

FILE: sv/pkps_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkps_req_if
// Byte channel into the scanner.
// ----------------------------------------------------------------------------
interface pkps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: sv/pkps_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkps_rsp_if
// Summary channel out of the scanner.
// ----------------------------------------------------------------------------
interface pkps_rsp_if;
   import pkps_pkg::*;
   logic               valid;
   logic               ready;
   logic               status;
   logic               malformed;
   logic               has_javascript;
   logic               has_launch;
   logic               has_embedded_file;
   logic               has_open_action;
   logic               xref_absent;
   logic               eof_absent;
   logic [TALLY_W-1:0] object_total;

   modport source (output valid, output status, output malformed, output has_javascript,
                   output has_launch, output has_embedded_file, output has_open_action,
                   output xref_absent, output eof_absent, output object_total,
                   input ready);
   modport sink (input valid, input status, input malformed, input has_javascript,
                 input has_launch, input has_embedded_file, input has_open_action,
                 input xref_absent, input eof_absent, input object_total,
                 output ready);
endinterface
`default_nettype wire

FILE: sv/pdf_keyword_preflight_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_keyword_preflight_scanner
// Streams a document one byte per transfer and reports a keyword summary.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while the queue to the back has room. Every
// byte is compared in parallel against all keywords over a 13-byte window (a
// 12-byte shift register plus the incoming byte), so the front never waits
// on anything but the two-entry queue to the back. The back updates counters
// and flags one byte per cycle, bar the final-byte stall below, and, on the
// transfer with last_byte set, registers the summary and rsp_ch.valid, so the
// summary transfers at the earliest in the cycle after the back takes that
// byte. A finished summary waiting on rsp_ch stalls only the next document's
// final byte, not the bytes before. Counters, flags and history then clear.
module pdf_keyword_preflight_scanner (
   input logic         clock,
   input logic         reset,
   pkps_req_if.sink    req_ch,
   pkps_rsp_if.source  rsp_ch
);
   import pkps_pkg::*;

   class_type front_cls;
   logic      front_valid, front_ready;
   class_type back_item;
   logic      back_valid, back_ready;

   pkps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cls       (front_cls),
      .cls_valid (front_valid),
      .cls_ready (front_ready)
   );

   pkps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (front_cls),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_data   (back_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready)
   );

   pkps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .rsp_ch     (rsp_ch)
   );

   // a rejected length carries nothing but the status bit
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status |->
         !rsp_ch.malformed && !rsp_ch.has_javascript && !rsp_ch.has_launch &&
         !rsp_ch.has_embedded_file && !rsp_ch.has_open_action &&
         !rsp_ch.xref_absent && !rsp_ch.eof_absent && (rsp_ch.object_total == '0))
      else $error("rejected summary carries flags");

   // a well-formed summary needs objects and an end marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.status && !rsp_ch.malformed |->
         !rsp_ch.eof_absent && (rsp_ch.object_total != '0))
      else $error("well-formed summary without objects or end marker");

   // the queue is empty after reset, so bytes are taken at once
   assert property (@(posedge clock) reset |=> req_ch.ready)
      else $error("input not ready after reset");

   // a non-final byte in the queue never waits on the output side
   assert property (@(posedge clock) disable iff (reset)
      back_valid && !back_item.last |-> back_ready)
      else $error("back stalled on a byte without result");

endmodule
`default_nettype wire

FILE: sv/pkps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkps_front
// Byte history and parallel keyword compares; classifies each byte.
// ----------------------------------------------------------------------------
module pkps_front (
   input  logic                clock,
   input  logic                reset,
   pkps_req_if.sink            req_ch,
   output pkps_pkg::class_type cls,
   output logic                cls_valid,
   input  logic                cls_ready
);
   import pkps_pkg::*;

   localparam int unsigned HIST_BYTES = 12;
   localparam int unsigned HIST_BITS  = HIST_BYTES * 8;
   localparam int unsigned WIN_BITS   = HIST_BITS + 8;
   localparam logic [2:0]  HDR_LEN    = 3'd5;

   localparam logic [39:0]  PAT_HDR        = "%PDF-";
   localparam logic [31:0]  PAT_OBJ        = " obj";
   localparam logic [87:0]  PAT_JAVASCRIPT = "/JavaScript";
   localparam logic [23:0]  PAT_JS         = "/JS";
   localparam logic [55:0]  PAT_LAUNCH     = "/Launch";
   localparam logic [103:0] PAT_EMBEDDED   = "/EmbeddedFile";
   localparam logic [87:0]  PAT_OPEN       = "/OpenAction";
   localparam logic [31:0]  PAT_XREF       = "xref";
   localparam logic [39:0]  PAT_EOF        = "%%EOF";

   logic [HIST_BITS-1:0] hist_ff, hist_in;
   logic [2:0]           pos_ff, pos_in;
   logic [WIN_BITS-1:0]  window;
   logic [7:0]           hdr_char;
   logic                 take;

   assign req_ch.ready = cls_ready;
   assign cls_valid    = req_ch.valid;
   assign take         = req_ch.valid && cls_ready;

   // oldest byte in the top bits, current byte in the bottom
   assign window = {hist_ff, req_ch.data_byte};

   always_comb begin
      case (pos_ff)
         3'd0:    hdr_char = PAT_HDR[39:32];
         3'd1:    hdr_char = PAT_HDR[31:24];
         3'd2:    hdr_char = PAT_HDR[23:16];
         3'd3:    hdr_char = PAT_HDR[15:8];
         3'd4:    hdr_char = PAT_HDR[7:0];
         default: hdr_char = 8'h00;
      endcase
   end

   always_comb begin
      cls.hdr_bad    = (pos_ff < HDR_LEN) && (req_ch.data_byte != hdr_char);
      cls.obj        = (window[31:0] == PAT_OBJ);
      cls.javascript = (window[87:0] == PAT_JAVASCRIPT) || (window[23:0] == PAT_JS);
      cls.launch     = (window[55:0] == PAT_LAUNCH);
      cls.embedded   = (window[103:0] == PAT_EMBEDDED);
      cls.auto_open  = (window[87:0] == PAT_OPEN);
      cls.xref       = (window[31:0] == PAT_XREF);
      cls.eof        = (window[39:0] == PAT_EOF);
      cls.last       = req_ch.last_byte;
   end

   always_comb begin
      hist_in = hist_ff;
      pos_in  = pos_ff;
      if (take) begin
         if (req_ch.last_byte) begin
            // no match may span two documents
            hist_in = '0;
            pos_in  = '0;
         end else begin
            hist_in = {hist_ff[HIST_BITS-9:0], req_ch.data_byte};
            if (pos_ff < HDR_LEN) begin
               pos_in = pos_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         pos_ff  <= '0;
      end else begin
         hist_ff <= hist_in;
         pos_ff  <= pos_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/pkps_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkps_queue
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module pkps_queue (
   input  logic                clock,
   input  logic                reset,
   input  pkps_pkg::class_type push_data,
   input  logic                push_valid,
   output logic                push_ready,
   output pkps_pkg::class_type pop_data,
   output logic                pop_valid,
   input  logic                pop_ready
);
   import pkps_pkg::*;

   class_type         mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/pkps_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkps_back
// Byte count, object tally and seen flags; builds and holds the summary.
// ----------------------------------------------------------------------------
module pkps_back (
   input  logic                clock,
   input  logic                reset,
   input  pkps_pkg::class_type item,
   input  logic                item_valid,
   output logic                item_ready,
   pkps_rsp_if.source          rsp_ch
);
   import pkps_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_LEN);

   logic [CNT_W-1:0]   bytes_ff, bytes_in, bytes_next;
   logic [TALLY_W-1:0] tally_ff, tally_in, tally_next;
   logic               good_ff, good_in, good_next;
   logic               js_ff, launch_ff, embed_ff, open_ff, xref_ff, eof_ff;
   logic               js_in, launch_in, embed_in, open_in, xref_in, eof_in;
   logic               rsp_valid_ff, rsp_valid_in;
   summary_type        sum_ff, sum_in;
   logic               take, finish;

   // bytes that cause no result never wait on the output register
   assign item_ready = !item.last || !rsp_valid_ff || rsp_ch.ready;
   assign take       = item_valid && item_ready;
   assign finish     = take && item.last;

   always_comb begin
      bytes_next = (bytes_ff <= CNT_MAX) ? bytes_ff + CNT_W'(1) : bytes_ff;
      tally_next = (item.obj && (tally_ff != '1)) ? tally_ff + TALLY_W'(1) : tally_ff;
      good_next  = good_ff && !item.hdr_bad;
      js_in      = js_ff || item.javascript;
      launch_in  = launch_ff || item.launch;
      embed_in   = embed_ff || item.embedded;
      open_in    = open_ff || item.auto_open;
      xref_in    = xref_ff || item.xref;
      eof_in     = eof_ff || item.eof;
   end

   always_comb begin
      sum_in = '0;
      if ((bytes_next < CNT_MIN) || (bytes_next > CNT_MAX)) begin
         sum_in.status = 1'b1;
      end else if (!good_next) begin
         sum_in.malformed = 1'b1;
      end else begin
         sum_in.malformed         = (tally_next == '0) || !eof_in;
         sum_in.has_javascript    = js_in;
         sum_in.has_launch        = launch_in;
         sum_in.has_embedded_file = embed_in;
         sum_in.has_open_action   = open_in;
         sum_in.xref_absent       = !xref_in;
         sum_in.eof_absent        = !eof_in;
         sum_in.object_total      = tally_next;
      end
   end

   always_comb begin
      bytes_in = bytes_ff;
      tally_in = tally_ff;
      good_in  = good_ff;
      if (take) begin
         bytes_in = finish ? '0 : bytes_next;
         tally_in = finish ? '0 : tally_next;
         good_in  = finish ? 1'b1 : good_next;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff     <= '0;
         tally_ff     <= '0;
         good_ff      <= 1'b1;
         js_ff        <= 1'b0;
         launch_ff    <= 1'b0;
         embed_ff     <= 1'b0;
         open_ff      <= 1'b0;
         xref_ff      <= 1'b0;
         eof_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bytes_ff     <= bytes_in;
         tally_ff     <= tally_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            js_ff     <= js_in && !finish;
            launch_ff <= launch_in && !finish;
            embed_ff  <= embed_in && !finish;
            open_ff   <= open_in && !finish;
            xref_ff   <= xref_in && !finish;
            eof_ff    <= eof_in && !finish;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         sum_ff <= sum_in;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = sum_ff.status;
   assign rsp_ch.malformed         = sum_ff.malformed;
   assign rsp_ch.has_javascript    = sum_ff.has_javascript;
   assign rsp_ch.has_launch        = sum_ff.has_launch;
   assign rsp_ch.has_embedded_file = sum_ff.has_embedded_file;
   assign rsp_ch.has_open_action   = sum_ff.has_open_action;
   assign rsp_ch.xref_absent       = sum_ff.xref_absent;
   assign rsp_ch.eof_absent        = sum_ff.eof_absent;
   assign rsp_ch.object_total      = sum_ff.object_total;

endmodule
`default_nettype wire
